// ----- src/pcsl_pkg.sv -----
// Shared constants, register codes and configuration struct for the slew-limited PID controller.
package pcsl_pkg;

  localparam int SMOOTH_TAPS  = 4;
  localparam int DEFAULT_STEP = 655;

  localparam int DATA_W  = 32;
  localparam int DT_W    = 16;
  localparam int INT_W   = 48;
  localparam int BND_W   = 47;
  localparam int ULIM_W  = 31;
  localparam int APB_DW  = 64;
  localparam int APB_AW  = 6;
  localparam int DIV_W   = 48;
  localparam int DIVS_W  = 16;
  localparam int MUL_AW  = 48;
  localparam int MUL_BW  = 32;
  localparam int PROD_W  = MUL_AW + MUL_BW;
  localparam int FRAC_W  = 16;
  localparam int TERM_W  = 64;

  localparam logic [2:0] REG_PROP  = 3'd0;
  localparam logic [2:0] REG_INTEG = 3'd1;
  localparam logic [2:0] REG_DERIV = 3'd2;
  localparam logic [2:0] REG_ZONE  = 3'd3;
  localparam logic [2:0] REG_BOUND = 3'd4;
  localparam logic [2:0] REG_LOW   = 3'd5;
  localparam logic [2:0] REG_HIGH  = 3'd6;
  localparam logic [2:0] REG_SLEW  = 3'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integ_gain;
    logic signed [DATA_W-1:0] deriv_gain;
    logic [ULIM_W-1:0]        integral_zone;
    logic [BND_W-1:0]         integral_bound;
    logic signed [DATA_W-1:0] out_low;
    logic signed [DATA_W-1:0] out_high;
    logic [ULIM_W-1:0]        slew_limit;
  } cfg_t;

endpackage

// ----- src/pid_controller_slew_limited.sv -----
// PID controller with integral zone, slope smoothing and output slew limit.
// Each item runs through the bit-serial divider (slope, then smoothed derivative) and
// four shift-add multiplies before the result is registered.
// One item at a time; the next item is taken once
// the result is in the output register, even while that result is still stalled.
// Reset (rst_ni low, async): history, integral, last error/output cleared, registers to defaults.
module pid_controller_slew_limited #(
  parameter int SmoothTaps  = pcsl_pkg::SMOOTH_TAPS,
  parameter int DefaultStep = pcsl_pkg::DEFAULT_STEP
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pcsl_pkg::APB_AW-1:0]          paddr,
  input  logic [pcsl_pkg::APB_DW-1:0]          pwdata,
  output logic [pcsl_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [pcsl_pkg::DATA_W-1:0]   error_in_i,
  input  logic [pcsl_pkg::DT_W-1:0]            step_time_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pcsl_pkg::DATA_W-1:0]   drive_out_o
);

  localparam int SumW = pcsl_pkg::DATA_W + $clog2(SmoothTaps) + 1;
  localparam int DW   = pcsl_pkg::DATA_W;
  localparam int IW   = pcsl_pkg::INT_W;
  localparam int TW   = pcsl_pkg::TERM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SLOPE, S_SLOPE_W, S_DERIV, S_DERIV_W, S_IMUL, S_IMUL_W, S_IBND,
    S_PMUL, S_PMUL_W, S_DMUL, S_DMUL_W, S_KMUL, S_KMUL_W, S_SLEW, S_CLAMP
  } state_e;

  pcsl_pkg::cfg_t cfg;

  state_e                  state_q;
  logic                    seen_q, out_valid_q;
  logic signed [DW-1:0]    last_err_q, last_out_q, out_q;
  logic signed [DW-1:0]    e_q, deriv_q;
  logic [pcsl_pkg::DT_W-1:0] dt_q;
  logic                    dneg_q, sc_q, inzone_q;
  logic [DW-1:0]           dmag_q;
  logic signed [DW-1:0]    hist_q [SmoothTaps];
  logic signed [SumW-1:0]  sum_q;
  logic signed [IW-1:0]    integ_q;
  logic signed [TW-1:0]    target_q, o_q;

  logic                    accept;
  logic [pcsl_pkg::DT_W-1:0] dt_eff;
  logic signed [DW-1:0]    prev;
  logic signed [DW:0]      diff;
  logic [DW-1:0]           diff_mag, e_mag, in_mag;
  logic                    div_start, div_done, mul_start, mul_done, mul_neg;
  logic [pcsl_pkg::DIV_W-1:0]  div_dvd, div_quot;
  logic [pcsl_pkg::DIVS_W-1:0] div_dvs;
  logic [pcsl_pkg::MUL_AW-1:0] mul_a;
  logic [pcsl_pkg::MUL_BW-1:0] mul_b;
  logic signed [TW-1:0]    mul_res;
  logic signed [DW-1:0]    slope, deriv_new;
  logic signed [SumW-1:0]  sum_new;
  logic [SumW-1:0]         sum_mag;
  logic signed [IW-1:0]    ibase, isat, ibnd, bnd_pos;
  logic signed [IW:0]      iacc;
  logic signed [TW:0]      sdiff, slim;
  logic signed [TW-1:0]    o_new, lo64, hi64, fin;
  logic signed [DW-1:0]    lo, hi;

  function automatic logic [DW-1:0] mag32(input logic signed [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  pcsl_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  pcsl_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dvd), .divisor_i(div_dvs),
    .done_o(div_done), .quotient_o(div_quot)
  );

  pcsl_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_mag_i(mul_a), .b_mag_i(mul_b),
    .neg_i(mul_neg), .done_o(mul_done), .result_o(mul_res)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign drive_out_o = out_q;

  always_comb begin
    dt_eff   = (step_time_i == '0) ? pcsl_pkg::DT_W'(DefaultStep) : step_time_i;
    prev     = seen_q ? last_err_q : error_in_i;
    diff     = {error_in_i[DW-1], error_in_i} - {prev[DW-1], prev};
    diff_mag = diff[DW] ? DW'(-diff) : diff[DW-1:0];
    in_mag   = mag32(error_in_i);
    e_mag    = mag32(e_q);

    // divider operands: slope first, then the smoothed sum over the taps
    div_start = (state_q == S_SLOPE) || (state_q == S_DERIV);
    sum_mag   = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
    if (state_q == S_SLOPE) begin
      div_dvd = {dmag_q, {pcsl_pkg::FRAC_W{1'b0}}};
      div_dvs = dt_q;
    end else begin
      div_dvd = pcsl_pkg::DIV_W'(sum_mag);
      div_dvs = pcsl_pkg::DIVS_W'(SmoothTaps);
    end

    if (dneg_q) begin
      slope = (div_quot > pcsl_pkg::DIV_W'(64'h8000_0000)) ? 32'sh8000_0000
            : -signed'(div_quot[DW-1:0]);
    end else begin
      slope = (div_quot > pcsl_pkg::DIV_W'(64'h7fff_ffff)) ? 32'sh7fff_ffff
            : signed'(div_quot[DW-1:0]);
    end
    sum_new   = sum_q + SumW'(slope) - SumW'(hist_q[SmoothTaps-1]);
    deriv_new = sum_q[SumW-1] ? -signed'(div_quot[DW-1:0]) : signed'(div_quot[DW-1:0]);

    mul_start = (state_q == S_IMUL) || (state_q == S_PMUL) ||
                (state_q == S_DMUL) || (state_q == S_KMUL);
    case (state_q)
      S_IMUL: begin
        mul_a = pcsl_pkg::MUL_AW'(e_mag);
        mul_b = pcsl_pkg::MUL_BW'(dt_q);
        mul_neg = e_q[DW-1];
      end
      S_PMUL: begin
        mul_a = pcsl_pkg::MUL_AW'(e_mag);
        mul_b = mag32(cfg.prop_gain);
        mul_neg = e_q[DW-1] ^ cfg.prop_gain[DW-1];
      end
      S_DMUL: begin
        mul_a = pcsl_pkg::MUL_AW'(mag32(deriv_q));
        mul_b = mag32(cfg.deriv_gain);
        mul_neg = deriv_q[DW-1] ^ cfg.deriv_gain[DW-1];
      end
      default: begin
        mul_a = integ_q[IW-1] ? pcsl_pkg::MUL_AW'(-integ_q) : pcsl_pkg::MUL_AW'(integ_q);
        mul_b = mag32(cfg.integ_gain);
        mul_neg = integ_q[IW-1] ^ cfg.integ_gain[DW-1];
      end
    endcase

    // integral accumulate, 48-bit saturation, restart on sign change, zone clear, optional bound
    ibase = sc_q ? '0 : integ_q;
    iacc  = {ibase[IW-1], ibase} + (IW+1)'(mul_res);
    if (iacc[IW] != iacc[IW-1]) begin
      isat = iacc[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end else begin
      isat = iacc[IW-1:0];
    end
    bnd_pos = signed'({1'b0, cfg.integral_bound});
    if (!inzone_q) begin
      ibnd = '0;
    end else if (cfg.integral_bound != '0 && integ_q > bnd_pos) begin
      ibnd = bnd_pos;
    end else if (cfg.integral_bound != '0 && integ_q < -bnd_pos) begin
      ibnd = -bnd_pos;
    end else begin
      ibnd = integ_q;
    end

    sdiff = {target_q[TW-1], target_q} - (TW+1)'(last_out_q);
    slim  = signed'((TW+1)'(cfg.slew_limit));
    if (sdiff > slim) begin
      sdiff = slim;
    end else if (sdiff < -slim) begin
      sdiff = -slim;
    end
    o_new = (cfg.slew_limit != '0) ? (TW'(last_out_q) + TW'(sdiff)) : target_q;

    if (cfg.out_low > cfg.out_high) begin
      lo = cfg.out_high;
      hi = cfg.out_low;
    end else begin
      lo = cfg.out_low;
      hi = cfg.out_high;
    end
    lo64 = TW'(lo);
    hi64 = TW'(hi);
    fin  = (o_q < lo64) ? lo64 : ((o_q > hi64) ? hi64 : o_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
      last_err_q  <= '0;
      last_out_q  <= '0;
      sum_q       <= '0;
      integ_q     <= '0;
      for (int i = 0; i < SmoothTaps; i++) hist_q[i] <= '0;
    end else begin
      // the final stage sets the flag itself when it hands over a new result
      if (out_valid_q && !out_stall_i && state_q != S_CLAMP) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            e_q        <= error_in_i;
            dt_q       <= dt_eff;
            dneg_q     <= diff[DW];
            dmag_q     <= diff_mag;
            sc_q       <= (!error_in_i[DW-1] && error_in_i != '0 && prev[DW-1]) ||
                          (error_in_i[DW-1] && !prev[DW-1] && prev != '0);
            inzone_q   <= (cfg.integral_zone != '0) && (in_mag < DW'(cfg.integral_zone));
            last_err_q <= error_in_i;
            seen_q     <= 1'b1;
            state_q    <= S_SLOPE;
          end
        end
        S_SLOPE:   state_q <= S_SLOPE_W;
        S_SLOPE_W: begin
          if (div_done) begin
            hist_q[0] <= slope;
            for (int i = 1; i < SmoothTaps; i++) hist_q[i] <= hist_q[i-1];
            sum_q   <= sum_new;
            state_q <= S_DERIV;
          end
        end
        S_DERIV:   state_q <= S_DERIV_W;
        S_DERIV_W: begin
          if (div_done) begin
            deriv_q <= deriv_new;
            state_q <= S_IMUL;
          end
        end
        S_IMUL:   state_q <= S_IMUL_W;
        S_IMUL_W: begin
          if (mul_done) begin
            integ_q <= isat;
            state_q <= S_IBND;
          end
        end
        S_IBND: begin
          integ_q <= ibnd;
          state_q <= S_PMUL;
        end
        S_PMUL:   state_q <= S_PMUL_W;
        S_PMUL_W: begin
          if (mul_done) begin
            target_q <= mul_res;
            state_q  <= S_DMUL;
          end
        end
        S_DMUL:   state_q <= S_DMUL_W;
        S_DMUL_W: begin
          if (mul_done) begin
            target_q <= target_q + mul_res;
            state_q  <= S_KMUL;
          end
        end
        S_KMUL:   state_q <= S_KMUL_W;
        S_KMUL_W: begin
          if (mul_done) begin
            target_q <= target_q + mul_res;
            state_q  <= S_SLEW;
          end
        end
        S_SLEW: begin
          o_q     <= o_new;
          state_q <= S_CLAMP;
        end
        S_CLAMP: begin
          // wait for the output register to free up
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= fin[DW-1:0];
            last_out_q  <= fin[DW-1:0];
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("block not busy after taking an item");

  a_result_from_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_CLAMP))
    else $error("result appeared outside the final stage");

  a_seen_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seen_q)
    else $error("result without any sample taken");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_done && mul_done))
    else $error("divider and multiplier finished together");

endmodule

// ----- src/pcsl_div.sv -----
// Restoring divider, one quotient bit per cycle.
module pcsl_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pcsl_pkg::DIV_W-1:0]    dividend_i,
  input  logic [pcsl_pkg::DIVS_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [pcsl_pkg::DIV_W-1:0]    quotient_o
);

  localparam int CntW = $clog2(pcsl_pkg::DIV_W);

  logic                          run_q, done_q;
  logic [CntW-1:0]               cnt_q;
  logic [pcsl_pkg::DIV_W-1:0]    dvd_q;
  logic [pcsl_pkg::DIVS_W-1:0]   rem_q, dvs_q, rem_d;
  logic [pcsl_pkg::DIVS_W:0]     trial, trial_sub;
  logic                          ge;

  always_comb begin
    trial     = {rem_q, dvd_q[pcsl_pkg::DIV_W-1]};
    trial_sub = trial - {1'b0, dvs_q};
    ge        = trial >= {1'b0, dvs_q};
    rem_d     = ge ? trial_sub[pcsl_pkg::DIVS_W-1:0] : trial[pcsl_pkg::DIVS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(pcsl_pkg::DIV_W - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // quotient bits shift in where dividend bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[pcsl_pkg::DIV_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ----- src/pcsl_mul.sv -----
// Shift-add multiplier, one multiplier bit per cycle, result (a*b)>>16 toward zero.
module pcsl_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [pcsl_pkg::MUL_AW-1:0]         a_mag_i,
  input  logic [pcsl_pkg::MUL_BW-1:0]         b_mag_i,
  input  logic                                neg_i,
  output logic                                done_o,
  output logic signed [pcsl_pkg::TERM_W-1:0]  result_o
);

  localparam int CntW = $clog2(pcsl_pkg::MUL_BW);

  logic                              run_q, done_q, neg_q;
  logic [CntW-1:0]                   cnt_q;
  logic [pcsl_pkg::MUL_AW-1:0]       a_q;
  logic [pcsl_pkg::MUL_BW-1:0]       b_q;
  logic [pcsl_pkg::PROD_W-1:0]       prod_q;
  logic [pcsl_pkg::MUL_AW:0]         part;
  logic [pcsl_pkg::PROD_W:0]         shifted;
  logic [pcsl_pkg::TERM_W-1:0]       mag;

  always_comb begin
    part    = {1'b0, prod_q[pcsl_pkg::PROD_W-1:pcsl_pkg::MUL_BW]}
            + (b_q[0] ? {1'b0, a_q} : '0);
    shifted = {part, prod_q[pcsl_pkg::MUL_BW-1:0]};
    mag     = prod_q[pcsl_pkg::PROD_W-1:pcsl_pkg::FRAC_W];
    result_o = neg_q ? -signed'(mag) : signed'(mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(pcsl_pkg::MUL_BW - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_mag_i;
      b_q    <= b_mag_i;
      neg_q  <= neg_i;
      prod_q <= '0;
    end else if (run_q) begin
      b_q    <= b_q >> 1;
      prod_q <= shifted[pcsl_pkg::PROD_W:1];
    end
  end

  assign done_o = done_q;

endmodule

// ----- src/pcsl_cfg.sv -----
// APB configuration register file.
module pcsl_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcsl_pkg::APB_AW-1:0]   paddr,
  input  logic [pcsl_pkg::APB_DW-1:0]   pwdata,
  output logic [pcsl_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output pcsl_pkg::cfg_t                cfg_o
);

  pcsl_pkg::cfg_t cfg_q;
  logic [2:0]     idx;
  logic           wr;

  assign idx    = paddr[pcsl_pkg::APB_AW-1:3];
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    case (idx)
      pcsl_pkg::REG_PROP:  prdata = {32'b0, cfg_q.prop_gain};
      pcsl_pkg::REG_INTEG: prdata = {32'b0, cfg_q.integ_gain};
      pcsl_pkg::REG_DERIV: prdata = {32'b0, cfg_q.deriv_gain};
      pcsl_pkg::REG_ZONE:  prdata = {33'b0, cfg_q.integral_zone};
      pcsl_pkg::REG_BOUND: prdata = {17'b0, cfg_q.integral_bound};
      pcsl_pkg::REG_LOW:   prdata = {32'b0, cfg_q.out_low};
      pcsl_pkg::REG_HIGH:  prdata = {32'b0, cfg_q.out_high};
      pcsl_pkg::REG_SLEW:  prdata = {33'b0, cfg_q.slew_limit};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain      <= '0;
      cfg_q.integ_gain     <= '0;
      cfg_q.deriv_gain     <= '0;
      cfg_q.integral_zone  <= '0;
      cfg_q.integral_bound <= '0;
      cfg_q.out_low        <= 32'sh8000_0000;
      cfg_q.out_high       <= 32'sh7fff_ffff;
      cfg_q.slew_limit     <= '0;
    end else if (wr) begin
      case (idx)
        pcsl_pkg::REG_PROP:  cfg_q.prop_gain      <= pwdata[31:0];
        pcsl_pkg::REG_INTEG: cfg_q.integ_gain     <= pwdata[31:0];
        pcsl_pkg::REG_DERIV: cfg_q.deriv_gain     <= pwdata[31:0];
        pcsl_pkg::REG_ZONE:  cfg_q.integral_zone  <= pwdata[30:0];
        pcsl_pkg::REG_BOUND: cfg_q.integral_bound <= pwdata[46:0];
        pcsl_pkg::REG_LOW:   cfg_q.out_low        <= pwdata[31:0];
        pcsl_pkg::REG_HIGH:  cfg_q.out_high       <= pwdata[31:0];
        pcsl_pkg::REG_SLEW:  cfg_q.slew_limit     <= pwdata[30:0];
        default: ;
      endcase
    end
  end

endmodule
